// File: rtl/fst_pkg.sv
// Shared types and constants of the format string tokenizer.
package fst_pkg;

  localparam int unsigned MAX_RESULTS = 3;

  // Segment kinds.
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_VAR   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_ID_ZERO    = 3'd0;
  localparam logic [2:0] ERR_END_IN_VAR = 3'd1;
  localparam logic [2:0] ERR_EXPECTED   = 3'd2;
  localparam logic [2:0] ERR_STRAY      = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } fst_in_t;

  typedef struct packed {
    logic [1:0]  seg_kind;
    logic [15:0] var_number;
    logic [15:0] span_begin;
    logic [15:0] span_end;
    logic [2:0]  error_code;
    logic        string_done;
  } fst_out_t;

  // All results caused by one input byte, in order from slot 0.
  typedef struct packed {
    fst_out_t [MAX_RESULTS-1:0] slots;
    logic [1:0]                 count;
  } fst_bundle_t;

endpackage

// File: rtl/fst_front.sv
// Parser front end: one byte per cycle while the queue has room; builds its bundle.
module fst_front import fst_pkg::*; #(
  parameter int unsigned POS_WIDTH = 16,
  parameter int unsigned ID_WIDTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fst_in_t     item_i,
  input  logic        push_i,
  input  logic        q_full_i,
  output fst_bundle_t bundle_o,
  output logic        bundle_valid_o
);

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_OPEN,
    MODE_DIGITS,
    MODE_SPEC,
    MODE_RUN,
    MODE_CLOSE,
    MODE_ERROR
  } mode_e;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam logic [ID_WIDTH-1:0]  ID_MAX  = '1;
  localparam logic [ID_WIDTH+4:0]  ID_SAT  = {5'b00001, {ID_WIDTH{1'b0}}};

  mode_e                mode_q, mode_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [POS_WIDTH-1:0] tb_q, tb_d;
  logic [ID_WIDTH-1:0]  auto_q, auto_d;
  logic [ID_WIDTH:0]    cur_q, cur_d;
  logic [POS_WIDTH-1:0] sb_q, sb_d;
  logic [POS_WIDTH-1:0] rfb_q, rfb_d;
  logic [POS_WIDTH-1:0] rl_q, rl_d;

  logic accept;

  function automatic logic [15:0] p16(logic [POS_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [15:0] v16(logic [ID_WIDTH:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic fst_out_t mk(logic [1:0] kind, logic [15:0] var_n, logic [15:0] b,
                                  logic [15:0] e, logic [2:0] err);
    fst_out_t r;
    r.seg_kind    = kind;
    r.var_number  = var_n;
    r.span_begin  = b;
    r.span_end    = e;
    r.error_code  = err;
    r.string_done = 1'b0;
    return r;
  endfunction

  // Text resumes half the brace run (rounded up) past its first brace.
  function automatic logic [POS_WIDTH-1:0] close_tb(logic [POS_WIDTH-1:0] rfb,
                                                    logic [POS_WIDTH-1:0] rl);
    logic [POS_WIDTH:0] s;
    s = {1'b0, rl} + {{POS_WIDTH{1'b0}}, 1'b1};
    return rfb + s[POS_WIDTH:1];
  endfunction

  assign accept = push_i && !q_full_i;

  always_comb begin
    logic [7:0]           c;
    logic [3:0]           digit;
    logic                 is_digit;
    logic [ID_WIDTH+4:0]  prod;
    logic [POS_WIDTH-1:0] i;
    logic [POS_WIDTH-1:0] tb2;
    logic                 do_after;
    logic [ID_WIDTH:0]    aid;
    fst_out_t [1:0]       cres;
    fst_out_t [1:0]       fres;
    logic [1:0]           nc;
    logic [1:0]           nf;
    logic [2:0]           total;
    logic [1:0]           cnt;

    c        = item_i.char_code;
    digit    = c[3:0] - CHAR_ZERO[3:0];
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    i        = pos_q;
    prod     = '0;
    tb2      = '0;
    do_after = 1'b0;
    aid      = '0;
    cres     = '0;
    fres     = '0;
    nc       = 2'd0;
    nf       = 2'd0;

    mode_d = mode_q;
    pos_d  = pos_q;
    tb_d   = tb_q;
    auto_d = auto_q;
    cur_d  = cur_q;
    sb_d   = sb_q;
    rfb_d  = rfb_q;
    rl_d   = rl_q;

    // Per-byte step.
    if (mode_q != MODE_ERROR) begin
      if (i == POS_MAX) begin
        cres[nc[0]] = mk(KIND_ERROR, 16'd0, p16(POS_MAX), 16'd0, ERR_TOO_LONG);
        nc = nc + 2'd1;
        mode_d = MODE_ERROR;
      end else begin
        unique case (mode_q)
          MODE_OPEN: begin
            if (c == CHAR_LBRACE) begin
              tb_d   = i;
              mode_d = MODE_TEXT;
            end else if (is_digit) begin
              cur_d  = (ID_WIDTH+1)'(digit);
              sb_d   = i;
              mode_d = MODE_DIGITS;
            end else begin
              if (auto_q != ID_MAX) auto_d = auto_q + 1'b1;
              aid      = {1'b0, auto_q};
              do_after = 1'b1;
            end
          end
          MODE_DIGITS: begin
            if (is_digit) begin
              prod = ({4'b0, cur_q} << 3) + ({4'b0, cur_q} << 1) + (ID_WIDTH+5)'(digit);
              if (prod > ID_SAT) prod = ID_SAT;
              cur_d = prod[ID_WIDTH:0];
            end else if (cur_q == '0) begin
              cres[nc[0]] = mk(KIND_ERROR, 16'd0, p16(sb_q), 16'd0, ERR_ID_ZERO);
              nc = nc + 2'd1;
              mode_d = MODE_ERROR;
            end else begin
              aid      = cur_q - 1'b1;
              do_after = 1'b1;
            end
          end
          MODE_SPEC: begin
            if (c == CHAR_RBRACE) begin
              rfb_d  = i;
              rl_d   = {{(POS_WIDTH-1){1'b0}}, 1'b1};
              mode_d = MODE_RUN;
            end
          end
          MODE_RUN: begin
            if (c == CHAR_RBRACE) begin
              rl_d = rl_q + 1'b1;
            end else if (rl_q[0]) begin
              cres[nc[0]] = mk(KIND_VAR, v16(cur_q), p16(sb_q), p16(rfb_q), ERR_ID_ZERO);
              nc = nc + 2'd1;
              tb_d   = close_tb(rfb_q, rl_q);
              mode_d = MODE_TEXT;
              if (c == CHAR_LBRACE) begin
                if (i > tb_d) begin
                  cres[nc[0]] = mk(KIND_TEXT, 16'd0, p16(tb_d), p16(i), ERR_ID_ZERO);
                  nc = nc + 2'd1;
                end
                mode_d = MODE_OPEN;
              end else if (c == CHAR_RBRACE) begin
                rfb_d  = i;
                mode_d = MODE_CLOSE;
              end
            end else begin
              mode_d = MODE_SPEC;
            end
          end
          MODE_CLOSE: begin
            if (c == CHAR_RBRACE) begin
              if (rfb_q > tb_q) begin
                cres[nc[0]] = mk(KIND_TEXT, 16'd0, p16(tb_q), p16(rfb_q), ERR_ID_ZERO);
                nc = nc + 2'd1;
              end
              tb_d   = i;
              mode_d = MODE_TEXT;
            end else begin
              cres[nc[0]] = mk(KIND_ERROR, 16'd0, p16(rfb_q), 16'd0, ERR_STRAY);
              nc = nc + 2'd1;
              mode_d = MODE_ERROR;
            end
          end
          default: begin
            if (c == CHAR_LBRACE) begin
              if (i > tb_q) begin
                cres[nc[0]] = mk(KIND_TEXT, 16'd0, p16(tb_q), p16(i), ERR_ID_ZERO);
                nc = nc + 2'd1;
              end
              mode_d = MODE_OPEN;
            end else if (c == CHAR_RBRACE) begin
              rfb_d  = i;
              mode_d = MODE_CLOSE;
            end
          end
        endcase

        // The identifier is settled: a colon, a closing brace or nothing else may follow.
        if (do_after) begin
          cur_d = aid;
          if (c == CHAR_COLON) begin
            sb_d   = i + 1'b1;
            mode_d = MODE_SPEC;
          end else if (c == CHAR_RBRACE) begin
            cres[nc[0]] = mk(KIND_VAR, v16(aid), p16(i), p16(i), ERR_ID_ZERO);
            nc = nc + 2'd1;
            tb_d   = i + 1'b1;
            mode_d = MODE_TEXT;
          end else begin
            cres[nc[0]] = mk(KIND_ERROR, 16'd0, p16(i), 16'd0, ERR_EXPECTED);
            nc = nc + 2'd1;
            mode_d = MODE_ERROR;
          end
        end
        pos_d = i + 1'b1;
      end
    end

    // End of string: flush what is open, then return to the reset state.
    if (item_i.is_final) begin
      unique case (mode_d)
        MODE_TEXT: begin
          if (pos_d > tb_d) begin
            fres[0] = mk(KIND_TEXT, 16'd0, p16(tb_d), p16(pos_d), ERR_ID_ZERO);
            nf = 2'd1;
          end
        end
        MODE_OPEN, MODE_SPEC: begin
          fres[0] = mk(KIND_ERROR, 16'd0, p16(pos_d), 16'd0, ERR_END_IN_VAR);
          nf = 2'd1;
        end
        MODE_DIGITS: begin
          if (cur_d == '0) fres[0] = mk(KIND_ERROR, 16'd0, p16(sb_d), 16'd0, ERR_ID_ZERO);
          else fres[0] = mk(KIND_ERROR, 16'd0, p16(pos_d), 16'd0, ERR_END_IN_VAR);
          nf = 2'd1;
        end
        MODE_RUN: begin
          if (rl_d[0]) begin
            fres[0] = mk(KIND_VAR, v16(cur_d), p16(sb_d), p16(rfb_d), ERR_ID_ZERO);
            nf = 2'd1;
            tb2 = close_tb(rfb_d, rl_d);
            if (pos_d > tb2) begin
              fres[1] = mk(KIND_TEXT, 16'd0, p16(tb2), p16(pos_d), ERR_ID_ZERO);
              nf = 2'd2;
            end
          end else begin
            fres[0] = mk(KIND_ERROR, 16'd0, p16(pos_d), 16'd0, ERR_END_IN_VAR);
            nf = 2'd1;
          end
        end
        MODE_CLOSE: begin
          fres[0] = mk(KIND_ERROR, 16'd0, p16(rfb_d), 16'd0, ERR_STRAY);
          nf = 2'd1;
        end
        default: ;
      endcase

      mode_d = MODE_TEXT;
      pos_d  = '0;
      tb_d   = '0;
      auto_d = '0;
      cur_d  = '0;
      sb_d   = '0;
      rfb_d  = '0;
      rl_d   = '0;
    end

    // Pack byte-step results first, then end-of-string results.
    bundle_o.slots[0] = (nc != 2'd0) ? cres[0] : fres[0];
    bundle_o.slots[1] = (nc == 2'd2) ? cres[1] : ((nc == 2'd1) ? fres[0] : fres[1]);
    bundle_o.slots[2] = (nc == 2'd2) ? fres[0] : fres[1];
    total = {1'b0, nc} + {1'b0, nf};
    cnt   = total[1:0];
    if (item_i.is_final) begin
      if (cnt == 2'd0) begin
        bundle_o.slots[0] = mk(KIND_END, 16'd0, 16'd0, 16'd0, ERR_ID_ZERO);
        cnt = 2'd1;
      end
      bundle_o.slots[cnt - 2'd1].string_done = 1'b1;
    end
    bundle_o.count = cnt;
    bundle_valid_o = accept && (cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      pos_q  <= '0;
      tb_q   <= '0;
      auto_q <= '0;
      cur_q  <= '0;
      sb_q   <= '0;
      rfb_q  <= '0;
      rl_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      tb_q   <= tb_d;
      auto_q <= auto_d;
      cur_q  <= cur_d;
      sb_q   <= sb_d;
      rfb_q  <= rfb_d;
      rl_q   <= rl_d;
    end
  end

endmodule

// File: rtl/fst_queue.sv
// Short queue of result bundles between the parser and the output stage.
module fst_queue import fst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fst_bundle_t wdata_i,
  input  logic        wr_i,
  output logic        full_o,
  output fst_bundle_t rdata_o,
  input  logic        rd_i,
  output logic        empty_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  fst_bundle_t       mem_q [DEPTH];
  logic [AW-1:0]     wptr_q, rptr_q;
  logic [AW:0]       cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      if (wr_i && !rd_i) cnt_q <= cnt_q + 1'b1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/fst_back.sv
// Output stage: hands out each bundle's results one per cycle while pop is held.
module fst_back import fst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fst_bundle_t bundle_i,
  input  logic        q_empty_i,
  output logic        q_rd_o,
  output fst_out_t    result_o,
  output logic        empty_o,
  input  logic        pop_i
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q;
  fst_out_t   out_q;
  logic       load;
  logic       last;

  // The output register refills whenever the queue holds a bundle and it is free or being taken.
  assign load   = !q_empty_i && (!valid_q || pop_i);
  assign last   = (idx_q == bundle_i.count - 2'd1);
  assign q_rd_o = load && last;
  assign idx_d  = load ? (last ? 2'd0 : idx_q + 2'd1) : idx_q;

  assign result_o = out_q;
  assign empty_o  = !valid_q;

  always_ff @(posedge clk_i) begin
    if (load) out_q <= bundle_i.slots[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) valid_q <= 1'b1;
      else if (pop_i) valid_q <= 1'b0;
    end
  end

endmodule

// File: rtl/format_string_tokenizer.sv
// Brace format string tokenizer: one byte in, zero to three segment descriptors out.
// A byte is taken every cycle while the four-bundle queue has room; the results it
// causes go into the queue as one bundle, then through the output register.
// Results leave the output register at one per cycle while pop is held, so bytes
// causing several results are absorbed by the queue. Reset clears the parser state
// and empties the queue and output register.
module format_string_tokenizer import fst_pkg::*; #(
  parameter int unsigned POS_WIDTH = 16,
  parameter int unsigned ID_WIDTH  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fst_in_t  item_i,
  input  logic     push,
  output logic     full,
  output fst_out_t result_o,
  output logic     empty,
  input  logic     pop
);

  fst_bundle_t wr_bundle;
  fst_bundle_t rd_bundle;
  logic        q_wr;
  logic        q_rd;
  logic        q_full;
  logic        q_empty;

  fst_front #(
    .POS_WIDTH(POS_WIDTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .push_i        (push),
    .q_full_i      (q_full),
    .bundle_o      (wr_bundle),
    .bundle_valid_o(q_wr)
  );

  fst_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wdata_i(wr_bundle),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rdata_o(rd_bundle),
    .rd_i   (q_rd),
    .empty_o(q_empty)
  );

  fst_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (rd_bundle),
    .q_empty_i(q_empty),
    .q_rd_o   (q_rd),
    .result_o (result_o),
    .empty_o  (empty),
    .pop_i    (pop)
  );

  assign full = q_full;

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> !q_full) else $error("bundle written into a full queue");

  a_no_read_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_empty) else $error("bundle read from an empty queue");

  a_end_marker_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.seg_kind == KIND_END) |-> result_o.string_done)
    else $error("end marker without string_done");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> empty) else $error("output not empty during reset");

endmodule

// File: test/tb_format_string_tokenizer.sv
// Self-checking testbench of the format string tokenizer, with its own segment predictor.
module tb_format_string_tokenizer;
  import fst_pkg::*;

  localparam int unsigned POS_MAX     = 65535;
  localparam int unsigned ID_MAX      = 65535;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef enum logic [2:0] {
    ST_TEXT, ST_OPEN, ST_DIGITS, ST_SPEC, ST_RUN, ST_CLOSE, ST_ERROR
  } parse_state_e;

  logic     clk_i;
  logic     rst_ni;
  fst_in_t  item_i = '0;
  logic     push   = 1'b0;
  logic     full;
  fst_out_t result_o;
  logic     empty;
  logic     pop    = 1'b0;

  // Predictor state, kept wide so that saturation and the position limit are exact.
  parse_state_e st;
  int unsigned  cur_pos;
  int unsigned  txt_begin;
  int unsigned  auto_cnt;
  int unsigned  cur_id;
  int unsigned  spec_begin;
  int unsigned  run_first;
  int unsigned  run_len;

  fst_out_t    step_segs[$];
  fst_out_t    pending_segs[$];
  logic [7:0]  str_q[$];
  fst_out_t    want;
  int unsigned sent_count = 0;
  int unsigned fail_count = 0;
  bit          calm = 1'b0;

  format_string_tokenizer uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .push     (push),
    .full     (full),
    .result_o (result_o),
    .empty    (empty),
    .pop      (pop)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_parser();
    st         = ST_TEXT;
    cur_pos    = 0;
    txt_begin  = 0;
    auto_cnt   = 0;
    cur_id     = 0;
    spec_begin = 0;
    run_first  = 0;
    run_len    = 0;
  endfunction

  function automatic void add_seg(input logic [1:0] kind, input int unsigned var_n,
                                  input int unsigned b, input int unsigned e,
                                  input logic [2:0] err);
    fst_out_t r;
    r.seg_kind    = kind;
    r.var_number  = var_n[15:0];
    r.span_begin  = b[15:0];
    r.span_end    = e[15:0];
    r.error_code  = err;
    r.string_done = 1'b0;
    step_segs = {step_segs, r};
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    str_q = {str_q, c};
  endfunction

  function automatic void raise_error(input logic [2:0] code, input int unsigned where);
    add_seg(KIND_ERROR, 0, where, 0, code);
    st = ST_ERROR;
  endfunction

  function automatic void flush_text(input int unsigned stop);
    if (stop > txt_begin) add_seg(KIND_TEXT, 0, txt_begin, stop, '0);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic void text_byte(input logic [7:0] c, input int unsigned i);
    if (c == CHAR_LBRACE) begin
      flush_text(i);
      st = ST_OPEN;
    end else if (c == CHAR_RBRACE) begin
      run_first = i;
      st        = ST_CLOSE;
    end
  endfunction

  function automatic void after_number(input logic [7:0] c, input int unsigned i,
                                       input int unsigned id);
    cur_id = id;
    if (c == CHAR_COLON) begin
      spec_begin = i + 1;
      st         = ST_SPEC;
    end else if (c == CHAR_RBRACE) begin
      add_seg(KIND_VAR, id, i, i, '0);
      txt_begin = i + 1;
      st        = ST_TEXT;
    end else begin
      raise_error(ERR_EXPECTED, i);
    end
  endfunction

  // An odd run of closing braces ends the field at its first brace; the rest are
  // escapes that the next text segment picks up.
  function automatic void close_field();
    add_seg(KIND_VAR, cur_id, spec_begin, run_first, '0);
    txt_begin = run_first + (run_len + 1) / 2;
    st        = ST_TEXT;
  endfunction

  // Works out every segment that one accepted byte causes and queues them in order.
  function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
    int unsigned i;
    int unsigned id;
    int unsigned d;
    fst_out_t    last;
    step_segs.delete();
    i = cur_pos;
    d = int'(c) - int'(CHAR_ZERO);
    if (st != ST_ERROR) begin
      if (i >= POS_MAX) begin
        raise_error(ERR_TOO_LONG, POS_MAX);
      end else begin
        case (st)
          ST_OPEN: begin
            if (c == CHAR_LBRACE) begin
              txt_begin = i;
              st        = ST_TEXT;
            end else if (is_digit(c)) begin
              cur_id     = d;
              spec_begin = i;
              st         = ST_DIGITS;
            end else begin
              id = auto_cnt;
              if (auto_cnt < ID_MAX) auto_cnt++;
              after_number(c, i, id);
            end
          end
          ST_DIGITS: begin
            if (is_digit(c)) begin
              cur_id = cur_id * 10 + d;
              if (cur_id > ID_MAX + 1) cur_id = ID_MAX + 1;
            end else if (cur_id == 0) begin
              raise_error(ERR_ID_ZERO, spec_begin);
            end else begin
              after_number(c, i, cur_id - 1);
            end
          end
          ST_SPEC: begin
            if (c == CHAR_RBRACE) begin
              run_first = i;
              run_len   = 1;
              st        = ST_RUN;
            end
          end
          ST_RUN: begin
            if (c == CHAR_RBRACE) begin
              run_len++;
            end else if (run_len % 2 == 1) begin
              close_field();
              text_byte(c, i);
            end else begin
              st = ST_SPEC;
            end
          end
          ST_CLOSE: begin
            if (c == CHAR_RBRACE) begin
              flush_text(run_first);
              txt_begin = i;
              st        = ST_TEXT;
            end else begin
              raise_error(ERR_STRAY, run_first);
            end
          end
          default: text_byte(c, i);
        endcase
        cur_pos = i + 1;
      end
    end
    if (fin) begin
      case (st)
        ST_TEXT:         flush_text(cur_pos);
        ST_OPEN,
        ST_SPEC:         raise_error(ERR_END_IN_VAR, cur_pos);
        ST_DIGITS: begin
          if (cur_id == 0) raise_error(ERR_ID_ZERO, spec_begin);
          else raise_error(ERR_END_IN_VAR, cur_pos);
        end
        ST_RUN: begin
          if (run_len % 2 == 1) begin
            close_field();
            flush_text(cur_pos);
          end else begin
            raise_error(ERR_END_IN_VAR, cur_pos);
          end
        end
        ST_CLOSE:        raise_error(ERR_STRAY, run_first);
        default: ;
      endcase
      if (step_segs.size() == 0) add_seg(KIND_END, 0, 0, 0, '0);
      last = step_segs.pop_back();
      last.string_done = 1'b1;
      step_segs = {step_segs, last};
      clear_parser();
    end
    pending_segs = {pending_segs, step_segs};
  endfunction

  // Called at a rising edge; returns at the rising edge at which the byte is taken.
  task automatic send_byte(input logic [7:0] c, input logic fin);
    fst_in_t nxt;
    nxt.char_code = c;
    nxt.is_final  = fin;
    while (!calm && $urandom_range(99) < 16) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    item_i <= nxt;
    push   <= 1'b1;
    do @(negedge clk_i); while (full);
    // Inputs stay put until the next edge, so the request is taken there.
    tokenize_byte(c, fin);
    sent_count++;
    @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CHAR_LBRACE || c == CHAR_RBRACE);
    return c;
  endfunction

  // Mostly well-formed strings of text, escapes and fields, with some noise and cut-offs.
  function automatic void fill_random_string();
    int unsigned pieces;
    int unsigned n;
    logic [7:0]  c;
    str_q.delete();
    pieces = $urandom_range(1, 4);
    repeat (pieces) begin
      n = $urandom_range(99);
      if (n < 30) begin
        repeat ($urandom_range(1, 3)) add_byte(plain_char());
      end else if (n < 38) begin
        add_byte(CHAR_LBRACE);
        add_byte(CHAR_LBRACE);
      end else if (n < 46) begin
        add_byte(CHAR_RBRACE);
        add_byte(CHAR_RBRACE);
      end else if (n < 82) begin
        add_byte(CHAR_LBRACE);
        case ($urandom_range(3))
          0: ;
          1: begin
            c = CHAR_ZERO + 8'($urandom_range(1, 9));
            add_byte(c);
          end
          2: repeat ($urandom_range(1, 3)) begin
            c = CHAR_ZERO + 8'($urandom_range(9));
            add_byte(c);
          end
          default: begin
            c = CHAR_ZERO + 8'($urandom_range(1, 9));
            add_byte(c);
            repeat ($urandom_range(4, 5)) begin
              c = CHAR_ZERO + 8'($urandom_range(9));
              add_byte(c);
            end
          end
        endcase
        if ($urandom_range(1)) begin
          add_byte(CHAR_COLON);
          repeat ($urandom_range(4)) begin
            if ($urandom_range(3) == 0) begin
              add_byte(CHAR_RBRACE);
              add_byte(CHAR_RBRACE);
            end else begin
              add_byte(plain_char());
            end
          end
        end
        repeat (($urandom_range(3) == 0) ? 2 * $urandom_range(1, 2) + 1 : 1)
          add_byte(CHAR_RBRACE);
      end else if (n < 90) begin
        case ($urandom_range(2))
          0:       add_byte(CHAR_LBRACE);
          1:       add_byte(CHAR_RBRACE);
          default: add_byte(CHAR_COLON);
        endcase
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
    if (str_q.size() > 1 && $urandom_range(9) == 0) void'(str_q.pop_back());
  endfunction

  task automatic test_fields_and_escapes();
    send_text("x{}{3:ab}}}c{}");
    send_text("{{}}{:}}z}");
    send_text("a}}");
    send_text("{99999}");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_error_paths();
    send_text("{:}}");
    send_text("{0}ab");
    send_text("{1x");
    send_text("a}b");
    send_text("}");
    send_text("{");
    send_text("{0");
    send_text("{12");
  endtask

  task automatic test_random_strings(input int unsigned n_bytes);
    int unsigned start;
    start = sent_count;
    while (sent_count - start < n_bytes) begin
      fill_random_string();
      for (int k = 0; k < str_q.size(); k++) send_byte(str_q[k], k == str_q.size() - 1);
    end
  endtask

  always @(posedge clk_i) pop <= calm || ($urandom_range(99) >= 16);

  always @(negedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_segs.size() == 0) begin
        $error("result with no segment expected: kind %0d", result_o.seg_kind);
        fail_count++;
      end else begin
        want = pending_segs.pop_front();
        if (result_o.seg_kind !== want.seg_kind) begin
          $error("seg_kind: expected %0d, got %0d", want.seg_kind, result_o.seg_kind);
          fail_count++;
        end
        if (result_o.var_number !== want.var_number) begin
          $error("var_number: expected %0d, got %0d", want.var_number, result_o.var_number);
          fail_count++;
        end
        if (result_o.span_begin !== want.span_begin) begin
          $error("span_begin: expected %0d, got %0d", want.span_begin, result_o.span_begin);
          fail_count++;
        end
        if (result_o.span_end !== want.span_end) begin
          $error("span_end: expected %0d, got %0d", want.span_end, result_o.span_end);
          fail_count++;
        end
        if (result_o.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, result_o.error_code);
          fail_count++;
        end
        if (result_o.string_done !== want.string_done) begin
          $error("string_done: expected %0d, got %0d", want.string_done,
                 result_o.string_done);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("tb_format_string_tokenizer: done, errors");
    $finish;
  end

  initial begin
    // Driven as an update so that the falling edge reaches the design's reset.
    rst_ni <= 1'b0;
    clear_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fields_and_escapes();
    test_error_paths();
    test_random_strings(25);
    calm = 1'b1;
    test_random_strings(35);
    calm = 1'b0;
    test_random_strings(25);
    push <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_format_string_tokenizer: done, clean");
    end else begin
      $display("tb_format_string_tokenizer: done, errors");
    end
    $finish;
  end

endmodule
